>>> design/nlp_pkg.sv
package nlp_pkg;

  // Default capacity of the stored string in bytes.
  localparam int unsigned MAX_LEN_DEF = 16;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned REQ_W  = 2;

  // Request codes carried in the input tuser field.
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EMIT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
    logic              no_successor;
    logic              empty_res;
  } res_t;

endpackage

>>> design/nlp_ram.sv
module nlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/nlp_out.sv
module nlp_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  nlp_pkg::res_t              res_i,
  output logic                       free_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [7:0]                 m_axis_tdata_o,  // [7:0] out_char
  output logic                       m_axis_tlast_o,
  output logic [1:0]                 m_axis_tuser_o   // [0] no_successor, [1] empty_res
);

  logic          valid_q, valid_d;
  nlp_pkg::res_t res_q, res_d;

  // The slot is free when empty or when its item leaves in this cycle.
  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (free_o) begin
      valid_d = push_i;
      if (push_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q.out_char;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tuser_o  = {res_q.empty_res, res_q.no_successor};

endmodule

>>> design/nlp_ctrl.sv
module nlp_ctrl #(
  parameter int unsigned MAX_LEN = nlp_pkg::MAX_LEN_DEF,
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [nlp_pkg::REQ_W-1:0]      req_type_i,
  input  logic [nlp_pkg::CHAR_W-1:0]     in_char_i,
  input  logic                           restart_i,
  input  logic                           out_free_i,
  output logic                           push_o,
  output nlp_pkg::res_t                  res_o,
  output logic                           we_o,
  output logic [AW-1:0]                  waddr_o,
  output logic [nlp_pkg::CHAR_W-1:0]     wdata_o,
  output logic                           re_o,
  output logic [AW-1:0]                  raddr_o,
  input  logic [nlp_pkg::CHAR_W-1:0]     rdata_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PIV  = 4'd1;
  localparam logic [3:0] S_SUC  = 4'd2;
  localparam logic [3:0] S_SWP1 = 4'd3;
  localparam logic [3:0] S_SWP2 = 4'd4;
  localparam logic [3:0] S_RVA  = 4'd5;
  localparam logic [3:0] S_RVB  = 4'd6;
  localparam logic [3:0] S_RVW1 = 4'd7;
  localparam logic [3:0] S_RVW2 = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  localparam int unsigned CW = nlp_pkg::CHAR_W;

  logic [3:0]    state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic          tl_q, tl_d;
  logic [AW-1:0] ra_q, ra_d;
  logic          ra_ok_q, ra_ok_d;
  logic          dv_q, dv_d;
  logic [AW-1:0] didx_q, didx_d;
  logic [CW-1:0] prev_q, prev_d;
  logic [AW-1:0] p_q, p_d;
  logic [CW-1:0] pval_q, pval_d;
  logic [AW-1:0] q_q, q_d;
  logic [CW-1:0] tmp_q, tmp_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [LW-1:0] ecnt_q, ecnt_d;
  logic          pend_q, pend_d;
  logic          nosucc_q, nosucc_d;

  logic [LW-1:0] nm1;
  logic [AW-1:0] nm1_a;
  logic [LW-1:0] eff_len;
  logic          eff_tl;
  logic          go;
  logic          load;
  logic          issue;

  assign nm1   = LW'(len_q - LW'(1));
  assign nm1_a = nm1[AW-1:0];

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    tl_d     = tl_q;
    ra_d     = ra_q;
    ra_ok_d  = ra_ok_q;
    dv_d     = 1'b0;
    didx_d   = didx_q;
    prev_d   = prev_q;
    p_d      = p_q;
    pval_d   = pval_q;
    q_d      = q_q;
    tmp_d    = tmp_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ecnt_d   = ecnt_q;
    pend_d   = pend_q;
    nosucc_d = nosucc_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = '0;
    re_o     = 1'b0;
    raddr_o  = '0;
    push_o   = 1'b0;
    res_o    = '0;
    go       = 1'b0;
    load     = 1'b0;
    issue    = 1'b0;
    eff_len  = restart_i ? '0 : len_q;
    eff_tl   = restart_i ? 1'b0 : tl_q;
    s_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          case (req_type_i)
            nlp_pkg::REQ_LOAD: begin
              len_d = eff_len;
              tl_d  = eff_tl;
              if (!eff_tl) begin
                if (eff_len == LW'(MAX_LEN)) begin
                  len_d = '0;
                  tl_d  = 1'b1;
                end else begin
                  we_o    = 1'b1;
                  waddr_o = eff_len[AW-1:0];
                  wdata_o = in_char_i;
                  len_d   = LW'(eff_len + LW'(1));
                end
              end
            end
            nlp_pkg::REQ_EMIT: begin
              state_d  = S_EMIT;
              nosucc_d = 1'b0;
              ecnt_d   = '0;
              pend_d   = 1'b0;
            end
            nlp_pkg::REQ_ADVANCE: begin
              ecnt_d = '0;
              pend_d = 1'b0;
              if (len_q < LW'(2)) begin
                state_d  = S_EMIT;
                nosucc_d = 1'b1;
              end else begin
                state_d  = S_PIV;
                nosucc_d = 1'b0;
                ra_d     = nm1_a;
                ra_ok_d  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Scan from the right for the first byte smaller than its right neighbor.
      S_PIV: begin
        if (dv_q) begin
          if (didx_q == nm1_a) begin
            prev_d = rdata_i;
          end else if (rdata_i < prev_q) begin
            p_d     = didx_q;
            pval_d  = rdata_i;
            state_d = S_SUC;
            ra_d    = nm1_a;
            ra_ok_d = 1'b1;
            go      = 1'b1;
          end else begin
            prev_d = rdata_i;
            if (didx_q == '0) begin
              nosucc_d = 1'b1;
              state_d  = S_EMIT;
              go       = 1'b1;
            end
          end
        end
        if (!go && ra_ok_q) begin
          re_o    = 1'b1;
          raddr_o = ra_q;
          dv_d    = 1'b1;
          didx_d  = ra_q;
          ra_d    = AW'(ra_q - AW'(1));
          ra_ok_d = (ra_q != '0);
        end
      end

      // Rightmost byte larger than the pivot; always found right of the pivot.
      S_SUC: begin
        if (dv_q && (rdata_i > pval_q)) begin
          q_d     = didx_q;
          tmp_d   = rdata_i;
          state_d = S_SWP1;
          go      = 1'b1;
        end
        if (!go && ra_ok_q) begin
          re_o    = 1'b1;
          raddr_o = ra_q;
          dv_d    = 1'b1;
          didx_d  = ra_q;
          ra_d    = AW'(ra_q - AW'(1));
          ra_ok_d = (ra_q != '0);
        end
      end

      S_SWP1: begin
        we_o    = 1'b1;
        waddr_o = p_q;
        wdata_o = tmp_q;
        state_d = S_SWP2;
      end

      S_SWP2: begin
        we_o    = 1'b1;
        waddr_o = q_q;
        wdata_o = pval_q;
        lo_d    = AW'(p_q + AW'(1));
        hi_d    = nm1_a;
        state_d = (AW'(p_q + AW'(1)) < nm1_a) ? S_RVA : S_EMIT;
      end

      // Suffix reversal: each byte pair goes through S_RVA, S_RVB, S_RVW1 and S_RVW2 in turn.
      S_RVA: begin
        re_o    = 1'b1;
        raddr_o = lo_q;
        state_d = S_RVB;
      end

      S_RVB: begin
        re_o    = 1'b1;
        raddr_o = hi_q;
        tmp_d   = rdata_i;
        state_d = S_RVW1;
      end

      S_RVW1: begin
        we_o    = 1'b1;
        waddr_o = lo_q;
        wdata_o = rdata_i;
        state_d = S_RVW2;
      end

      S_RVW2: begin
        we_o    = 1'b1;
        waddr_o = hi_q;
        wdata_o = tmp_q;
        lo_d    = AW'(lo_q + AW'(1));
        hi_d    = AW'(hi_q - AW'(1));
        state_d = (AW'(lo_q + AW'(1)) < AW'(hi_q - AW'(1))) ? S_RVA : S_EMIT;
      end

      S_EMIT: begin
        if (len_q == '0) begin
          if (out_free_i) begin
            push_o             = 1'b1;
            res_o.out_char     = '0;
            res_o.last         = 1'b1;
            res_o.no_successor = nosucc_q;
            res_o.empty_res    = 1'b1;
            state_d            = S_IDLE;
          end
        end else begin
          // pend_q means the read data holds the byte that has not gone out yet.
          load  = pend_q && out_free_i;
          issue = (ecnt_q != len_q) && (!pend_q || load);
          if (issue) begin
            re_o    = 1'b1;
            raddr_o = ecnt_q[AW-1:0];
            ecnt_d  = LW'(ecnt_q + LW'(1));
          end
          pend_d = issue || (pend_q && !load);
          if (load) begin
            push_o             = 1'b1;
            res_o.out_char     = rdata_i;
            res_o.last         = (ecnt_q == len_q);
            res_o.no_successor = nosucc_q;
            res_o.empty_res    = 1'b0;
            if (ecnt_q == len_q) begin
              state_d = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      len_q    <= '0;
      tl_q     <= 1'b0;
      ra_ok_q  <= 1'b0;
      dv_q     <= 1'b0;
      ecnt_q   <= '0;
      pend_q   <= 1'b0;
      nosucc_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      tl_q     <= tl_d;
      ra_ok_q  <= ra_ok_d;
      dv_q     <= dv_d;
      ecnt_q   <= ecnt_d;
      pend_q   <= pend_d;
      nosucc_q <= nosucc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q   <= ra_d;
    didx_q <= didx_d;
    prev_q <= prev_d;
    p_q    <= p_d;
    pval_q <= pval_d;
    q_q    <= q_d;
    tmp_q  <= tmp_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

endmodule

>>> design/next_lexicographic_permutation.sv
// Steps a stored byte string through its permutations in lexicographic order.
// Input items arrive on the s_axis channel: tuser selects load, emit or
// advance, tdata carries the byte and the restart flag of a load. Result
// items leave on m_axis, one per stored byte, with tlast on the final byte;
// an empty string gives a single zero byte flagged as empty.
// A load gives no result. An emit streams the bytes at one per cycle while
// the receiver takes them; each byte passes through the memory read register
// and then the output register. An advance first scans the string from the
// right for the pivot, scans again from the right for its successor byte,
// swaps the two with two writes and reverses the suffix one byte pair at a
// time with two reads and two writes, since the letter memory has one read
// and one write port; it then emits.
// Items are taken one at a time; s_axis_tready is high only while the
// sequencer is idle. A one-entry output register decouples the result side,
// so a stalled receiver halts the emission without losing a byte.
// Reset empties the string; the letter memory itself is not cleared.
module next_lexicographic_permutation #(
  parameter int unsigned MAX_LEN = nlp_pkg::MAX_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] in_char, [8] restart, rest zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_char
  output logic        m_axis_tlast_o,
  output logic [1:0]  m_axis_tuser_o   // [0] no_successor, [1] empty_res
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [nlp_pkg::CHAR_W-1:0]    wdata;
  logic                          re;
  logic [AW-1:0]                 raddr;
  logic [nlp_pkg::CHAR_W-1:0]    rdata;
  logic                          out_free;
  logic                          push;
  nlp_pkg::res_t                 res;

  nlp_ram #(
    .WIDTH (nlp_pkg::CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nlp_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .req_type_i (s_axis_tuser_i),
    .in_char_i  (s_axis_tdata_i[7:0]),
    .restart_i  (s_axis_tdata_i[8]),
    .out_free_i (out_free),
    .push_o     (push),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  nlp_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .res_i           (res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
